>>> rtl/periodic_task_slot_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task slot scheduler
// Same-cycle and next-cycle implication checks, each with its own message.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PTSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptss: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PTSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptss: next-cycle check failed");

`endif

>>> rtl/ptss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_pkg
// Field widths, command and status codes and shared types of the scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

   localparam int CMD_W     = 3;
   localparam int HANDLE_W  = 16;
   localparam int DELAY_W   = 16;
   localparam int PERIOD_W  = 16;
   localparam int RUNS_W    = 16;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 3;
   localparam int CNT_W     = 17;

   // a run scan reports at most this many due slots
   localparam int MAX_RESULTS = 8;
   localparam int DUE_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RUN    = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUE      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_REJECT   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_NONEDUE  = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } ptss_state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [CNT_W-1:0]    countdown;
      logic [PERIOD_W-1:0] period;
      logic [RUNS_W-1:0]   runs;
   } ptss_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [HANDLE_W-1:0] due_handle;
      logic                slot_freed;
      logic                last;
   } ptss_result_type;

   typedef struct packed {
      logic            push;
      ptss_result_type item;
   } ptss_push_type;

endpackage

>>> rtl/ptss_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface ptss_req_if import ptss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [HANDLE_W-1:0] task_handle;
   logic [DELAY_W-1:0]  start_delay;
   logic [PERIOD_W-1:0] period;
   logic [RUNS_W-1:0]   run_count;

   modport source (output valid, command, task_handle, start_delay, period, run_count,
                   input ready);
   modport sink   (input valid, command, task_handle, start_delay, period, run_count,
                   output ready);
   modport monitor (input valid, ready, command, task_handle, start_delay, period,
                    run_count);
endinterface

interface ptss_rsp_if import ptss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [HANDLE_W-1:0] due_handle;
   logic                slot_freed;
   logic                last;

   modport source (output valid, status, slot_index, due_handle, slot_freed, last,
                   input ready);
   modport sink   (input valid, status, slot_index, due_handle, slot_freed, last,
                   output ready);
   modport monitor (input valid, ready, status, slot_index, due_handle, slot_freed, last);
endinterface

>>> rtl/ptss_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_slot_ram
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptss_slot_ram import ptss_pkg::*; #(
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  ptss_entry_type    wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output ptss_entry_type    rd_data
);

   ptss_entry_type mem_ff [DEPTH];
   ptss_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ptss_rsp_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_rsp_stage
// Output register of the result channel; frees the engine from the sink.
// ----------------------------------------------------------------------------
module ptss_rsp_stage import ptss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ptss_push_type push,
   output logic          free,
   ptss_rsp_if.source    rsp_bus
);

   logic            valid_ff;
   ptss_result_type item_ff;

   assign free = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push.push) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         item_ff <= push.item;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.status     = item_ff.status;
   assign rsp_bus.slot_index = item_ff.slot_index;
   assign rsp_bus.due_handle = item_ff.due_handle;
   assign rsp_bus.slot_freed = item_ff.slot_freed;
   assign rsp_bus.last       = item_ff.last;

endmodule

>>> rtl/ptss_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_engine
// Command sequencer: sweeps the slot table through the slot memory one entry per
// cycle unless a run scan stalls, updates it in place and feeds the output stage.
// ----------------------------------------------------------------------------
module ptss_engine import ptss_pkg::*; #(
   parameter int NUM_SLOTS = 8,
   parameter int FOREVER_COUNT = 65535,
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   ptss_req_if.sink         req_bus,
   input  logic             rsp_free,
   output ptss_push_type    push,
   output logic [IDX_W-1:0] rd_addr,
   input  ptss_entry_type   rd_data,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output ptss_entry_type   wr_data
);

   localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [RUNS_W-1:0]   FOREVER  = RUNS_W'(FOREVER_COUNT);

   ptss_state_type state_ff, state_in;

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [RUNS_W-1:0]    runs_ff, runs_in;
   logic                 bad_ff, bad_in;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] written_ff, written_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;

   logic                 proc_v_ff, proc_v_in;
   logic [IDX_W-1:0]     proc_idx_ff, proc_idx_in;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     found_idx_ff, found_idx_in;
   logic [DUE_CNT_W-1:0] due_cnt_ff, due_cnt_in;
   logic                 held_v_ff, held_v_in;
   ptss_result_type      held_ff, held_in;

   logic                 accept;
   logic                 bad_cmd;
   logic                 hit_due;
   logic                 stall;
   logic                 due_freed;
   logic [CNT_W-1:0]     start_cd;
   ptss_entry_type       slot_q;
   ptss_result_type      final_item;

   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      unique case (req_bus.command)
         CMD_ADD:    bad_cmd = (req_bus.period == '0) || (req_bus.run_count == '0);
         CMD_CHANGE: bad_cmd = (req_bus.period == '0);
         CMD_DELETE: bad_cmd = 1'b0;
         CMD_TICK:   bad_cmd = 1'b0;
         CMD_RUN:    bad_cmd = 1'b0;
         default:    bad_cmd = 1'b1;
      endcase
   end

   // an entry never written since reset reads as all zero
   assign slot_q   = written_ff[proc_idx_ff] ? rd_data : '0;
   assign start_cd = {1'b0, delay_ff} + CNT_W'(1);
   assign hit_due  = valid_ff[proc_idx_ff] && (slot_q.countdown == '0) &&
                     (due_cnt_ff < DUE_CNT_W'(MAX_RESULTS));
   // hold the sweep while a due item is ready but the previous one cannot leave
   assign stall    = (state_ff == ST_SWEEP) && proc_v_ff && (cmd_ff == CMD_RUN) &&
                     hit_due && held_v_ff && !rsp_free;
   assign wr_addr  = proc_idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = bad_cmd ? ST_FINISH : ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (proc_v_ff && !stall && (proc_idx_ff == LAST_IDX)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // final result of the command
   always_comb begin
      final_item.status     = STAT_REJECT;
      final_item.slot_index = '0;
      final_item.due_handle = handle_ff;
      final_item.slot_freed = 1'b0;
      final_item.last       = 1'b1;
      unique case (cmd_ff)
         CMD_ADD: begin
            if (!bad_ff) begin
               if (found_ff) begin
                  final_item.status     = STAT_OK;
                  final_item.slot_index = SLOT_W'(found_idx_ff);
               end else begin
                  final_item.status = STAT_FULL;
               end
            end
         end
         CMD_DELETE: begin
            if (found_ff) begin
               final_item.status     = STAT_OK;
               final_item.slot_index = SLOT_W'(found_idx_ff);
            end else begin
               final_item.status = STAT_NOTFOUND;
            end
         end
         CMD_CHANGE: begin
            final_item.status     = bad_ff ? STAT_REJECT : STAT_OK;
            final_item.slot_index = SLOT_W'(cur_ff);
         end
         CMD_TICK: begin
            final_item.status     = STAT_OK;
            final_item.due_handle = '0;
         end
         CMD_RUN: begin
            if (held_v_ff) begin
               final_item      = held_ff;
               final_item.last = 1'b1;
            end else begin
               final_item.status     = STAT_NONEDUE;
               final_item.due_handle = '0;
            end
         end
         default: final_item.due_handle = '0;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_bus.ready = 1'b0;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      runs_in       = runs_ff;
      bad_in        = bad_ff;
      valid_in      = valid_ff;
      written_in    = written_ff;
      cur_in        = cur_ff;
      proc_v_in     = proc_v_ff;
      proc_idx_in   = proc_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      due_cnt_in    = due_cnt_ff;
      held_v_in     = held_v_ff;
      held_in       = held_ff;
      rd_addr       = proc_idx_ff;
      wr_en         = 1'b0;
      wr_data       = slot_q;
      push          = '0;
      due_freed     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            rd_addr       = '0;
            if (accept) begin
               cmd_in      = req_bus.command;
               handle_in   = req_bus.task_handle;
               delay_in    = req_bus.start_delay;
               period_in   = req_bus.period;
               runs_in     = req_bus.run_count;
               bad_in      = bad_cmd;
               found_in    = 1'b0;
               due_cnt_in  = '0;
               held_v_in   = 1'b0;
               proc_v_in   = !bad_cmd;
               proc_idx_in = '0;
            end
         end
         ST_SWEEP: begin
            if (proc_v_ff && !stall) begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (!found_ff && !valid_ff[proc_idx_ff]) begin
                        wr_en                 = 1'b1;
                        wr_data.handle        = handle_ff;
                        wr_data.countdown     = start_cd;
                        wr_data.period        = period_ff;
                        wr_data.runs          = runs_ff;
                        valid_in[proc_idx_ff] = 1'b1;
                        found_in              = 1'b1;
                        found_idx_in          = proc_idx_ff;
                     end
                  end
                  CMD_DELETE: begin
                     if (!found_ff && valid_ff[proc_idx_ff] &&
                         (slot_q.handle == handle_ff)) begin
                        valid_in[proc_idx_ff] = 1'b0;
                        found_in              = 1'b1;
                        found_idx_in          = proc_idx_ff;
                     end
                  end
                  CMD_CHANGE: begin
                     // keep the run count of the slot
                     if (proc_idx_ff == cur_ff) begin
                        wr_en                 = 1'b1;
                        wr_data.handle        = handle_ff;
                        wr_data.countdown     = start_cd;
                        wr_data.period        = period_ff;
                        valid_in[proc_idx_ff] = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (slot_q.countdown != '0) begin
                        wr_en             = 1'b1;
                        wr_data.countdown = slot_q.countdown - CNT_W'(1);
                     end
                  end
                  CMD_RUN: begin
                     if (hit_due) begin
                        wr_en             = 1'b1;
                        wr_data.countdown = {1'b0, slot_q.period};
                        cur_in            = proc_idx_ff;
                        if (slot_q.runs != FOREVER) begin
                           if (slot_q.runs <= RUNS_W'(1)) begin
                              wr_data.runs          = '0;
                              valid_in[proc_idx_ff] = 1'b0;
                              due_freed             = 1'b1;
                           end else begin
                              wr_data.runs = slot_q.runs - RUNS_W'(1);
                           end
                        end
                        // release the earlier due item, keep this one for last flag
                        if (held_v_ff) begin
                           push.push = 1'b1;
                           push.item = held_ff;
                        end
                        held_in.status     = STAT_DUE;
                        held_in.slot_index = SLOT_W'(proc_idx_ff);
                        held_in.due_handle = slot_q.handle;
                        held_in.slot_freed = due_freed;
                        held_in.last       = 1'b0;
                        held_v_in          = 1'b1;
                        due_cnt_in         = due_cnt_ff + DUE_CNT_W'(1);
                     end
                  end
                  default: ;
               endcase
               if (wr_en) begin
                  written_in[proc_idx_ff] = 1'b1;
               end
               if (proc_idx_ff == LAST_IDX) begin
                  proc_v_in = 1'b0;
               end else begin
                  proc_idx_in = proc_idx_ff + IDX_W'(1);
                  rd_addr     = proc_idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FINISH: begin
            push.push = rsp_free;
            push.item = final_item;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         written_ff <= '0;
         cur_ff     <= '0;
         proc_v_ff  <= 1'b0;
         found_ff   <= 1'b0;
         due_cnt_ff <= '0;
         held_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         written_ff <= written_in;
         cur_ff     <= cur_in;
         proc_v_ff  <= proc_v_in;
         found_ff   <= found_in;
         due_cnt_ff <= due_cnt_in;
         held_v_ff  <= held_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      handle_ff    <= handle_in;
      delay_ff     <= delay_in;
      period_ff    <= period_in;
      runs_ff      <= runs_in;
      bad_ff       <= bad_in;
      proc_idx_ff  <= proc_idx_in;
      found_idx_ff <= found_idx_in;
      held_ff      <= held_in;
   end

endmodule

>>> rtl/periodic_task_slot_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Time-triggered task slot table: add, delete, change, tick and run scan.
// ----------------------------------------------------------------------------
//   channel   direction  handshake     carries
//   req_bus   in         valid/ready   command, task_handle, start_delay,
//                                      period, run_count
//   rsp_bus   out        valid/ready   status, slot_index, due_handle,
//                                      slot_freed, last
//
// A command is accepted, then the sweep does one slot memory read per slot,
// then the final result is issued. A rejected or unknown command skips the
// sweep and goes to the final result. Each slot visit is bound by the
// single read port of the slot memory. A stalled result channel holds the
// sweep of a run scan and the final result. After reset no clearing pass runs:
// per-slot written bits make untouched entries read as zero.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler import ptss_pkg::*; #(
   parameter int NUM_SLOTS = 8,
   parameter int FOREVER_COUNT = 65535
) (
   input  logic       clock,
   input  logic       reset,
   ptss_req_if.sink   req_bus,
   ptss_rsp_if.source rsp_bus
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic             rsp_free;
   ptss_push_type    push;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;
   ptss_entry_type   rd_data;
   ptss_entry_type   wr_data;

   ptss_engine #(
      .NUM_SLOTS     (NUM_SLOTS),
      .FOREVER_COUNT (FOREVER_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_free (rsp_free),
      .push     (push),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   ptss_slot_ram #(
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptss_rsp_stage u_rsp_stage (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .free    (rsp_free),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> rtl/ptss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptss_checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "periodic_task_slot_scheduler_defines.svh"

module ptss_checker import ptss_pkg::*; (
   input logic        clock,
   input logic        reset,
   ptss_req_if.sink   req_bus,
   ptss_rsp_if.source rsp_bus
);

   // a waiting result item holds its payload
   `PTSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable(rsp_bus.status) && $stable(rsp_bus.slot_index) && $stable(rsp_bus.due_handle) && $stable(rsp_bus.last))

   // the block works on one command at a time
   `PTSS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)

   // only a due item may report a freed slot
   `PTSS_ASSERT_SAME(a_freed_is_due, clock, reset, rsp_bus.valid && rsp_bus.slot_freed, rsp_bus.status == STAT_DUE)

   // every command other than run scan answers with a single item
   `PTSS_ASSERT_SAME(a_single_is_last, clock, reset, rsp_bus.valid && (rsp_bus.status != STAT_DUE), rsp_bus.last && !rsp_bus.slot_freed)

   // an empty scan reports no slot and no handle
   `PTSS_ASSERT_SAME(a_none_due_blank, clock, reset, rsp_bus.valid && (rsp_bus.status == STAT_NONEDUE), (rsp_bus.slot_index == '0) && (rsp_bus.due_handle == '0))

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - periodic task slot scheduler testbench
// Opens with a short directed sequence of commands: rejects, a full table,
// finite, forever and spent run counts, change of the last run slot and
// unknown commands. Then it sends random command streams that keep the slot
// table busy. A scoreboard mirrors the slot table, predicts every response
// item and checks the responses in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb import ptss_pkg::*; ;

   localparam int                NUM_SLOTS     = 8;
   localparam logic [RUNS_W-1:0] FOREVER_RUNS  = 16'hFFFF;
   localparam int                CLK_PERIOD    = 12;
   localparam int                RANDOM_ITEMS  = 104;
   localparam int                CALM_ITEMS    = 30;
   localparam int                CMD_LATENCY   = NUM_SLOTS + 2;
   localparam logic [CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [HANDLE_W-1:0] task_handle;
      logic [DELAY_W-1:0]  start_delay;
      logic [PERIOD_W-1:0] period;
      logic [RUNS_W-1:0]   run_count;
   } sched_cmd_type;

   class task_table_checker;
      bit                  live[NUM_SLOTS];
      logic [HANDLE_W-1:0] owner[NUM_SLOTS];
      logic [CNT_W-1:0]    countdown[NUM_SLOTS];
      logic [PERIOD_W-1:0] reload[NUM_SLOTS];
      logic [RUNS_W-1:0]   runs_left[NUM_SLOTS];
      logic [SLOT_W-1:0]   last_run_slot;
      ptss_result_type     owed_results[$];
      int                  errors;

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            live[i]      = 1'b0;
            owner[i]     = '0;
            countdown[i] = '0;
            reload[i]    = '0;
            runs_left[i] = '0;
         end
         last_run_slot = '0;
         errors        = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void owe(logic [STATUS_W-1:0] st, int idx, logic [HANDLE_W-1:0] h,
                        logic freed, logic fin);
         ptss_result_type r;
         r.status     = st;
         r.slot_index = SLOT_W'(idx);
         r.due_handle = h;
         r.slot_freed = freed;
         r.last       = fin;
         owed_results.push_back(r);
      endfunction

      // update the mirrored table and queue the responses of one command
      function void note_command(sched_cmd_type c);
         int   slot;
         int   due_total;
         int   served;
         logic freed;
         slot      = -1;
         due_total = 0;
         served    = 0;
         case (c.command)
            CMD_ADD: begin
               if (c.period == '0 || c.run_count == '0) begin
                  owe(STAT_REJECT, 0, c.task_handle, 1'b0, 1'b1);
               end else begin
                  for (int i = NUM_SLOTS - 1; i >= 0; i--)
                     if (!live[i]) slot = i;
                  if (slot < 0) begin
                     owe(STAT_FULL, 0, c.task_handle, 1'b0, 1'b1);
                  end else begin
                     live[slot]      = 1'b1;
                     owner[slot]     = c.task_handle;
                     countdown[slot] = {1'b0, c.start_delay} + 1'b1;
                     reload[slot]    = c.period;
                     runs_left[slot] = c.run_count;
                     owe(STAT_OK, slot, c.task_handle, 1'b0, 1'b1);
                  end
               end
            end
            CMD_DELETE: begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (slot < 0 && live[i] && owner[i] == c.task_handle) slot = i;
               if (slot < 0) begin
                  owe(STAT_NOTFOUND, 0, c.task_handle, 1'b0, 1'b1);
               end else begin
                  live[slot] = 1'b0;
                  owe(STAT_OK, slot, c.task_handle, 1'b0, 1'b1);
               end
            end
            CMD_CHANGE: begin
               if (c.period == '0) begin
                  owe(STAT_REJECT, last_run_slot, c.task_handle, 1'b0, 1'b1);
               end else begin
                  // run count of the slot is kept
                  live[last_run_slot]      = 1'b1;
                  owner[last_run_slot]     = c.task_handle;
                  countdown[last_run_slot] = {1'b0, c.start_delay} + 1'b1;
                  reload[last_run_slot]    = c.period;
                  owe(STAT_OK, last_run_slot, c.task_handle, 1'b0, 1'b1);
               end
            end
            CMD_TICK: begin
               // empty slots count down too
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (countdown[i] != '0) countdown[i] = countdown[i] - 1'b1;
               owe(STAT_OK, 0, '0, 1'b0, 1'b1);
            end
            CMD_RUN: begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (live[i] && countdown[i] == '0) due_total++;
               if (due_total > MAX_RESULTS) due_total = MAX_RESULTS;
               for (int i = 0; i < NUM_SLOTS && served < due_total; i++) begin
                  if (live[i] && countdown[i] == '0) begin
                     last_run_slot = SLOT_W'(i);
                     countdown[i]  = {1'b0, reload[i]};
                     freed         = 1'b0;
                     if (runs_left[i] != FOREVER_RUNS) begin
                        // a spent count still makes this the last run
                        if (runs_left[i] <= 1) begin
                           runs_left[i] = '0;
                           live[i]      = 1'b0;
                           freed        = 1'b1;
                        end else begin
                           runs_left[i] = runs_left[i] - 1'b1;
                        end
                     end
                     served++;
                     owe(STAT_DUE, i, owner[i], freed, served == due_total);
                  end
               end
               if (due_total == 0) owe(STAT_NONEDUE, 0, '0, 1'b0, 1'b1);
            end
            default: begin
               owe(STAT_REJECT, 0, '0, 1'b0, 1'b1);
            end
         endcase
      endfunction

      task check_result(ptss_result_type got);
         ptss_result_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("unexpected item status %0d slot %0d handle %h",
                             got.status, got.slot_index, got.due_handle));
            return;
         end
         want = owed_results.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d exp %0d", got.status, want.status));
         if (got.slot_index !== want.slot_index)
            report($sformatf("slot_index got %0d exp %0d", got.slot_index,
                             want.slot_index));
         if (got.due_handle !== want.due_handle)
            report($sformatf("due_handle got %h exp %h", got.due_handle,
                             want.due_handle));
         if (got.slot_freed !== want.slot_freed)
            report($sformatf("slot_freed got %b exp %b", got.slot_freed,
                             want.slot_freed));
         if (got.last !== want.last)
            report($sformatf("last got %b exp %b", got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;

   task_table_checker sb = new();

   ptss_req_if req_bus();
   ptss_rsp_if rsp_bus();

   periodic_task_slot_scheduler #(
      .NUM_SLOTS(NUM_SLOTS),
      .FOREVER_COUNT(65535)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(2_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // response side: check every accepted item
   always @(posedge clock) begin
      ptss_result_type got;
      got.status     = rsp_bus.status;
      got.slot_index = rsp_bus.slot_index;
      got.due_handle = rsp_bus.due_handle;
      got.slot_freed = rsp_bus.slot_freed;
      got.last       = rsp_bus.last;
      if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_result(got);
   end

   // response side: stall in bursts until the calm phase
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   function automatic sched_cmd_type make_cmd(logic [CMD_W-1:0] cmd,
                                              logic [HANDLE_W-1:0] h,
                                              logic [DELAY_W-1:0] d,
                                              logic [PERIOD_W-1:0] p,
                                              logic [RUNS_W-1:0] r);
      sched_cmd_type c;
      c.command     = cmd;
      c.task_handle = h;
      c.start_delay = d;
      c.period      = p;
      c.run_count   = r;
      return c;
   endfunction

   // small values keep tasks firing; now and then a full-range value
   function automatic logic [15:0] pick_small(int zero_w, int max_w, int full_w, int lo);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_w) return '0;
      if (r < zero_w + max_w) return 16'hFFFF;
      if (r < zero_w + max_w + full_w) return 16'($urandom_range(0, 16'hFFFF));
      return 16'($urandom_range(lo, 4));
   endfunction

   function automatic sched_cmd_type random_command();
      sched_cmd_type c;
      int            pick;
      int            held[$];
      pick          = $urandom_range(0, 99);
      c.task_handle = pick_small(0, 0, 20, 0) + 16'($urandom_range(0, 11));
      c.start_delay = pick_small(0, 2, 6, 0);
      c.period      = pick_small(5, 2, 4, 1);
      c.run_count   = pick_small(4, 12, 4, 1);
      if (pick < 25) begin
         c.command = CMD_ADD;
      end else if (pick < 40) begin
         c.command = CMD_DELETE;
         for (int i = 0; i < NUM_SLOTS; i++)
            if (sb.live[i]) held.push_back(i);
         if (held.size() > 0 && $urandom_range(0, 9) < 7)
            c.task_handle = sb.owner[held[$urandom_range(0, held.size() - 1)]];
      end else if (pick < 50) begin
         c.command = CMD_CHANGE;
      end else if (pick < 75) begin
         c.command = CMD_TICK;
      end else if (pick < 97) begin
         c.command = CMD_RUN;
      end else begin
         c.command = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      return c;
   endfunction

   task automatic send_command(sched_cmd_type c);
      req_bus.valid       <= 1'b1;
      req_bus.command     <= c.command;
      req_bus.task_handle <= c.task_handle;
      req_bus.start_delay <= c.start_delay;
      req_bus.period      <= c.period;
      req_bus.run_count   <= c.run_count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_command(c);
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // hold the command channel until every owed response item is back
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      sched_cmd_type opening[$];
      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_TICK;
      req_bus.task_handle <= '0;
      req_bus.start_delay <= '0;
      req_bus.period      <= '0;
      req_bus.run_count   <= '0;

      opening.push_back(make_cmd(CMD_RUN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      opening.push_back(make_cmd(CMD_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0005));
      opening.push_back(make_cmd(CMD_ADD, 16'h0000, 16'h0000, 16'h0001, 16'h0000));
      opening.push_back(make_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, FOREVER_RUNS));
      opening.push_back(make_cmd(CMD_ADD, 16'h0001, 16'h0000, 16'h0002, FOREVER_RUNS));
      opening.push_back(make_cmd(CMD_ADD, 16'h0002, 16'h0000, 16'h0001, 16'h0001));
      opening.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_RUN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_CHANGE, 16'h0003, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_CHANGE, 16'h0003, 16'h0000, 16'h0003, 16'h0000));
      opening.push_back(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_RUN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_DELETE, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_DELETE, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
      for (int i = 0; i < 7; i++)
         opening.push_back(make_cmd(CMD_ADD, 16'h0010 + 16'(i), 16'h0000, 16'h0001,
                                    16'h0002));
      opening.push_back(make_cmd(CMD_ADD, 16'h0020, 16'h0000, 16'h0001, 16'h0002));
      opening.push_back(make_cmd(CMD_DELETE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
      opening.push_back(make_cmd(CMD_UNUSED_LO, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      opening.push_back(make_cmd(CMD_UNUSED_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) begin
         send_command(opening[i]);
         sender_gap();
      end
      hold_until_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (n == RANDOM_ITEMS / 2) hold_until_drained();
         send_command(random_command());
         sender_gap();
      end
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (3 * CMD_LATENCY) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
